/* sv/bts_pkg.sv */
// Shared types, constants and float helpers for the bilinear table sampler.
// Single-precision operations round toward zero and flush denormals to zero.
// No dependencies.
package bts_pkg;

  localparam int TABLE_SIDE = 128;
  localparam int SIDE_W     = $clog2(TABLE_SIDE);
  localparam int IDX_W      = 2 * SIDE_W;
  localparam int BANK_AW    = 2 * (SIDE_W - 1);
  localparam int BANK_DEPTH = (TABLE_SIDE * TABLE_SIDE) / 4;

  // pipeline slots: coordinate taps ready, weights ready, result register
  localparam int CRD_IDX_LAT = 15;
  localparam int CRD_OUT_LAT = 16;
  localparam int PIPE_DEPTH  = 24;

  // clamped coordinates map into this tap range
  localparam logic [SIDE_W-1:0] TAP_IDX_MIN = SIDE_W'(4);
  localparam logic [SIDE_W-1:0] TAP_IDX_MAX = SIDE_W'(124);

  localparam logic [31:0] K_SCALE      = 32'h3F44_EC4F;  // 10/13
  localparam logic [31:0] K_TENTH      = 32'h3DCC_CCCD;  // 0.1
  localparam logic [31:0] K_NEG12      = 32'hC140_0000;
  localparam logic [31:0] K_POS12      = 32'h4140_0000;
  localparam logic [31:0] K_FIVE       = 32'h40A0_0000;
  localparam logic [31:0] K_SIXTYFOUR  = 32'h4280_0000;
  localparam logic [31:0] K_ONE        = 32'h3F80_0000;
  localparam logic [31:0] K_NO_TABLE   = 32'hBF00_0000;  // -0.5
  localparam logic [31:0] K_QNAN       = 32'h7FC0_0000;
  localparam logic [31:0] K_INF        = 32'h7F80_0000;
  localparam logic [31:0] K_MAX_FIN    = 32'h7F7F_FFFF;
  localparam logic [31:0] K_SIGN       = 32'h8000_0000;
  localparam logic [31:0] K_INT_MIN    = 32'h8000_0000;
  localparam logic [31:0] K_INT_MAX    = 32'h7FFF_FFFF;
  localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;

  localparam logic [7:0] SEL_SCALE_A = 8'd2;
  localparam logic [7:0] SEL_SCALE_B = 8'd7;
  localparam logic [7:0] SEL_TENS    = 8'd13;

  localparam logic [0:0] CFG_SEL_MASK = 1'b0;
  localparam logic [0:0] CFG_TABLE_ON = 1'b1;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_SCALE = 2'd1,
    MODE_TENS  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CL_ZERO = 2'd0,
    CL_FIN  = 2'd1,
    CL_INF  = 2'd2,
    CL_NAN  = 2'd3
  } fcls_t;

  // unpacked float: value = m * 2^e
  typedef struct packed {
    fcls_t              cls;
    logic               sgn;
    logic [63:0]        m;
    logic signed [11:0] e;
  } xf_t;

  typedef struct packed {
    logic [31:0] a0;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [31:0] a3;
  } taps_t;

  function automatic xf_t fp_unpack(input logic [31:0] b);
    xf_t x;
    x     = '0;
    x.sgn = b[31];
    if (b[30:23] == EXP_ALL_ONES) begin
      x.cls = (b[22:0] != '0) ? CL_NAN : CL_INF;
    end else if (b[30:23] == 8'd0) begin
      x.cls = CL_ZERO;
    end else begin
      x.cls = CL_FIN;
      x.m   = {40'd0, 1'b1, b[22:0]};
      x.e   = $signed({4'b0, b[30:23]}) - 12'sd150;
    end
    return x;
  endfunction

  function automatic logic [5:0] lead64(input logic [63:0] m);
    logic [5:0] p;
    p = '0;
    for (int k = 0; k < 64; k++) begin
      if (m[k]) p = 6'(k);
    end
    return p;
  endfunction

  function automatic logic [31:0] fp_pack(input xf_t x);
    logic [5:0]         p;
    logic [63:0]        nm;
    logic signed [12:0] be;
    logic [31:0]        s;
    s  = {x.sgn, 31'd0};
    p  = lead64(x.m);
    nm = x.m << (6'd63 - p);
    be = $signed({x.e[11], x.e}) + $signed({7'b0, p}) + 13'sd127;
    if (x.cls == CL_NAN) return K_QNAN;
    if (x.cls == CL_INF) return s | K_INF;
    if (x.cls == CL_ZERO || x.m == '0) return s;
    if (be >= 13'sd255) return s | K_MAX_FIN;
    if (be <= 13'sd0) return s;
    return {x.sgn, be[7:0], nm[62:40]};
  endfunction

  function automatic xf_t fp_mul(input logic [31:0] a, input logic [31:0] b);
    xf_t         xa;
    xf_t         xb;
    xf_t         r;
    logic [47:0] pr;
    xa    = fp_unpack(a);
    xb    = fp_unpack(b);
    r     = '0;
    r.sgn = xa.sgn ^ xb.sgn;
    pr    = xa.m[23:0] * xb.m[23:0];
    if (xa.cls == CL_NAN || xb.cls == CL_NAN) begin
      r.cls = CL_NAN;
    end else if (xa.cls == CL_INF || xb.cls == CL_INF) begin
      r.cls = (xa.cls == CL_ZERO || xb.cls == CL_ZERO) ? CL_NAN : CL_INF;
    end else if (xa.cls == CL_ZERO || xb.cls == CL_ZERO) begin
      r.cls = CL_ZERO;
    end else begin
      r.cls = CL_FIN;
      r.m   = {16'd0, pr};
      r.e   = xa.e + xb.e;
    end
    return r;
  endfunction

  function automatic xf_t fp_norm61(input xf_t x);
    xf_t        r;
    logic [5:0] sh;
    r   = x;
    sh  = 6'd61 - lead64(x.m);
    r.m = x.m << sh;
    r.e = x.e - $signed({6'b0, sh});
    return r;
  endfunction

  function automatic xf_t fp_add(input xf_t a, input xf_t b);
    xf_t                r;
    xf_t                an;
    xf_t                bn;
    xf_t                t;
    logic signed [11:0] d;
    logic [63:0]        ym;
    logic [63:0]        mask;
    r  = '0;
    an = fp_norm61(a);
    bn = fp_norm61(b);
    if (a.cls == CL_NAN || b.cls == CL_NAN) begin
      r.cls = CL_NAN;
      return r;
    end
    if (a.cls == CL_INF && b.cls == CL_INF) begin
      if (a.sgn != b.sgn) begin
        r.cls = CL_NAN;
        return r;
      end
      return a;
    end
    if (a.cls == CL_INF) return a;
    if (b.cls == CL_INF) return b;
    if (a.cls == CL_ZERO) begin
      if (b.cls == CL_ZERO) begin
        r.cls = CL_ZERO;
        r.sgn = a.sgn & b.sgn;
        return r;
      end
      return b;
    end
    if (b.cls == CL_ZERO) return a;
    if (bn.e > an.e || (bn.e == an.e && bn.m > an.m)) begin
      t  = an;
      an = bn;
      bn = t;
    end
    d    = an.e - bn.e;
    mask = ~(64'hFFFF_FFFF_FFFF_FFFF << d[5:0]);
    if (d == 12'sd0) begin
      ym = bn.m;
    end else if (d > 12'sd63) begin
      ym = 64'd1;
    end else begin
      ym = (bn.m >> d[5:0]) | {63'd0, |(bn.m & mask)};
    end
    r.cls = CL_FIN;
    r.e   = an.e;
    r.sgn = an.sgn;
    r.m   = (an.sgn == bn.sgn) ? an.m + ym : an.m - ym;
    if (r.m == '0) begin
      r.cls = CL_ZERO;
      r.sgn = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [31:0] fp_to_i32(input logic [31:0] b);
    xf_t                x;
    logic [31:0]        mag;
    logic signed [11:0] nx;
    x   = fp_unpack(b);
    nx  = -x.e;
    mag = '0;
    if (x.cls == CL_NAN) return K_INT_MIN;
    if (x.cls == CL_ZERO) return '0;
    if (x.cls == CL_INF || x.e > 12'sd7) return x.sgn ? K_INT_MIN : K_INT_MAX;
    if (x.e >= 12'sd0) begin
      mag = 32'(x.m << x.e[2:0]);
    end else if (x.e > -12'sd25) begin
      mag = 32'(x.m >> nx[4:0]);
    end
    return x.sgn ? (32'd0 - mag) : mag;
  endfunction

  function automatic logic [31:0] fp_from_i32(input logic [31:0] v);
    xf_t x;
    x     = '0;
    x.cls = CL_FIN;
    x.sgn = v[31];
    x.m   = {32'd0, v[31] ? (32'd0 - v) : v};
    if (v == '0) return '0;
    return fp_pack(x);
  endfunction

  function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] ka;
    logic signed [32:0] kb;
    ka = a[31] ? -$signed({2'b00, a[30:0]}) : $signed({2'b00, a[30:0]});
    kb = b[31] ? -$signed({2'b00, b[30:0]}) : $signed({2'b00, b[30:0]});
    if (a[30:0] > K_INF[30:0] || b[30:0] > K_INF[30:0]) return 1'b0;
    return ka > kb;
  endfunction

  // NaN fails the first compare and lands on -12
  function automatic logic [31:0] fp_clamp12(input logic [31:0] c);
    logic [31:0] r;
    r = c;
    if (!fp_gt(r, K_NEG12)) r = K_NEG12;
    if (!fp_gt(K_POS12, r)) r = K_POS12;
    return r;
  endfunction

endpackage

/* sv/bts_coord.sv */
// Coordinate pipeline: rescale by mode, clamp, map to table space, split
// into tap index, fraction and complement weight. Uses bts_pkg.
module bts_coord
  import bts_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [31:0]       coord,
  input  mode_t             mode,
  output logic [SIDE_W-1:0] tap_idx,
  output logic [31:0]       frac,
  output logic [31:0]       wgt
);

  // odd quotient steps away from zero
  function automatic logic [31:0] tens_adjust(input logic [31:0] i);
    logic [31:0] r;
    r = i;
    if (i[0]) r = i + (i[31] ? 32'hFFFF_FFFF : 32'd1);
    return r;
  endfunction

  logic [31:0]       c1_r, c2_r, c3_r, c4_r, c5_r;
  mode_t             md1_r, md2_r, md3_r, md4_r, md5_r;
  logic [31:0]       p2_r, p3_r, p4_r, p5_r;
  xf_t               x1_r;
  logic [31:0]       i3_r;
  logic [31:0]       v4_r;
  logic [31:0]       g5_r;
  xf_t               d6_r;
  logic [31:0]       c6_r, p6_r;
  mode_t             md6_r;
  logic [31:0]       cs7_r;
  logic [31:0]       cc8_r;
  xf_t               x9_r;
  xf_t               x10_r;
  logic [31:0]       t11_r, t12_r;
  logic [SIDE_W-1:0] i12_r, i13_r, i14_r, i15_r;
  logic [31:0]       g12_r;
  xf_t               fx13_r;
  logic [31:0]       f14_r, f15_r, f16_r;
  xf_t               wx15_r;
  logic [31:0]       w16_r;

  logic [31:0] ti12;
  logic [31:0] cs7_nxt;

  always_comb ti12 = fp_to_i32(t11_r);

  always_comb begin
    unique case (md6_r)
      MODE_SCALE: cs7_nxt = p6_r;
      MODE_TENS:  cs7_nxt = fp_pack(d6_r);
      default:    cs7_nxt = c6_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // rescale product, 10/13 or 0.1
      c1_r  <= coord;
      md1_r <= mode;
      x1_r  <= fp_mul(coord, (mode == MODE_SCALE) ? K_SCALE : K_TENTH);
      c2_r  <= c1_r;
      md2_r <= md1_r;
      p2_r  <= fp_pack(x1_r);
      // nearest even multiple of ten
      c3_r  <= c2_r;
      md3_r <= md2_r;
      p3_r  <= p2_r;
      i3_r  <= tens_adjust(fp_to_i32(p2_r));
      c4_r  <= c3_r;
      md4_r <= md3_r;
      p4_r  <= p3_r;
      v4_r  <= (i3_r << 3) + (i3_r << 1);
      c5_r  <= c4_r;
      md5_r <= md4_r;
      p5_r  <= p4_r;
      g5_r  <= fp_from_i32(v4_r);
      c6_r  <= c5_r;
      md6_r <= md5_r;
      p6_r  <= p5_r;
      d6_r  <= fp_add(fp_unpack(c5_r), fp_unpack(g5_r ^ K_SIGN));
      cs7_r <= cs7_nxt;
      // clamp and t = 5c + 64, one rounding
      cc8_r <= fp_clamp12(cs7_r);
      x9_r  <= fp_mul(K_FIVE, cc8_r);
      x10_r <= fp_add(x9_r, fp_unpack(K_SIXTYFOUR));
      t11_r <= fp_pack(x10_r);
      // integer part and fraction
      t12_r  <= t11_r;
      i12_r  <= ti12[SIDE_W-1:0];
      g12_r  <= fp_from_i32(ti12);
      fx13_r <= fp_add(fp_unpack(t12_r), fp_unpack(g12_r ^ K_SIGN));
      i13_r  <= i12_r;
      f14_r  <= fp_pack(fx13_r);
      i14_r  <= i13_r;
      wx15_r <= fp_add(fp_unpack(K_ONE), fp_unpack(f14_r ^ K_SIGN));
      f15_r  <= f14_r;
      i15_r  <= i14_r;
      f16_r  <= f15_r;
      w16_r  <= fp_pack(wx15_r);
    end
  end

  assign tap_idx = i15_r;
  assign frac    = f16_r;
  assign wgt     = w16_r;

endmodule

/* sv/bts_table.sv */
// Sample table in four banks split by row and column parity, so the four
// bilinear taps read in the same cycle. Uses bts_pkg.
module bts_table
  import bts_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [31:0]       wr_value,
  input  logic              rd_en,
  input  logic [SIDE_W-1:0] col,
  input  logic [SIDE_W-1:0] row,
  output taps_t             taps
);

  logic [31:0] bank_q_r [4];
  logic        rpar_r;
  logic        cpar_r;

  for (genvar rb = 0; rb < 2; rb++) begin : g_row
    for (genvar cb = 0; cb < 2; cb++) begin : g_col
      logic [31:0]        bank_mem [BANK_DEPTH];
      logic [SIDE_W-1:0]  row_sel;
      logic [SIDE_W-1:0]  col_sel;
      logic [BANK_AW-1:0] rd_addr;
      logic [BANK_AW-1:0] wr_addr;
      logic               wr_hit;

      always_comb begin
        row_sel = (row[0] == 1'(rb)) ? row : row + SIDE_W'(1);
        col_sel = (col[0] == 1'(cb)) ? col : col + SIDE_W'(1);
        rd_addr = {row_sel[SIDE_W-1:1], col_sel[SIDE_W-1:1]};
        wr_addr = {wr_index[IDX_W-1:SIDE_W+1], wr_index[SIDE_W-1:1]};
        wr_hit  = (wr_index[SIDE_W] == 1'(rb)) && (wr_index[0] == 1'(cb));
      end

      always_ff @(posedge clk) begin
        if (en && wr_en && wr_hit) begin
          bank_mem[wr_addr] <= wr_value;
        end
        if (en && rd_en) begin
          bank_q_r[rb*2+cb] <= bank_mem[rd_addr];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && rd_en) begin
      rpar_r <= row[0];
      cpar_r <= col[0];
    end
  end

  // back to tap order: a0 (r,c), a1 (r,c+1), a2 (r+1,c), a3 (r+1,c+1)
  always_comb begin
    taps.a0 = bank_q_r[{rpar_r, cpar_r}];
    taps.a1 = bank_q_r[{rpar_r, ~cpar_r}];
    taps.a2 = bank_q_r[{~rpar_r, cpar_r}];
    taps.a3 = bank_q_r[{~rpar_r, ~cpar_r}];
  end

endmodule

/* sv/bilinear_table_sampler.sv */
// Bilinear table sampler top level. Uses bts_pkg, bts_coord, bts_table.
// Throughput: one item per cycle unless a held result stalls the pipe; the
// table sits in four parity banks with one read port each, so all four
// taps of a sample come in the same cycle.
// Reset (rst_n low, synchronous) clears the pipeline valids and both config
// registers; the table contents stay undefined until written.
module bilinear_table_sampler
  import bts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_kind,
  input  logic [IDX_W-1:0] in_entry_index,
  input  logic [31:0]      in_entry_value,
  input  logic [7:0]       in_selector,
  input  logic [31:0]      in_coord_a,
  input  logic [31:0]      in_coord_b,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_sample_bits,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [7:0]       cfg_wdata
);

  // config
  logic [7:0] sel_mask_r;
  logic       table_on_r;

  // per-slot valid and kind (1 = sample)
  logic [PIPE_DEPTH:1] vld_r;
  logic [PIPE_DEPTH:1] smp_r;

  // table write payload rides along to the memory slot
  logic [IDX_W-1:0] wr_idx_r [1:CRD_IDX_LAT];
  logic [31:0]      wr_val_r [1:CRD_IDX_LAT];

  logic        en;
  logic [7:0]  sel;
  mode_t       mode;
  logic        wr_fire;
  logic        rd_fire;

  logic [SIDE_W-1:0] idx_a;
  logic [SIDE_W-1:0] idx_b;
  logic [31:0]       frac_a, frac_b;
  logic [31:0]       wgt_a, wgt_b;
  taps_t             taps;

  // blend stages
  xf_t         m0_17_r, m1_17_r, m2_17_r, m3_17_r;
  logic [31:0] f2_17_r, w2_17_r;
  logic [31:0] p0_18_r, p1_18_r, p2_18_r, p3_18_r;
  logic [31:0] f2_18_r, w2_18_r;
  xf_t         n0_19_r, n1_19_r, q2_19_r, q3_19_r;
  logic [31:0] r3a_20_r, r2a_20_r;
  xf_t         q2_20_r, q3_20_r;
  xf_t         r2x_21_r, r3x_21_r;
  logic [31:0] r2_22_r, r3_22_r;
  xf_t         sx_23_r;
  logic [31:0] res_24_r;

  // whole pipe advances unless the result register is held
  assign out_valid = vld_r[PIPE_DEPTH] & smp_r[PIPE_DEPTH];
  assign en        = ~(out_valid & out_stall);
  assign in_stall  = ~en;

  always_comb begin
    sel = in_selector & sel_mask_r;
    if (sel == SEL_SCALE_A || sel == SEL_SCALE_B) begin
      mode = MODE_SCALE;
    end else if (sel == SEL_TENS) begin
      mode = MODE_TENS;
    end else begin
      mode = MODE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_mask_r <= '0;
      table_on_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEL_MASK: sel_mask_r <= cfg_wdata;
        CFG_TABLE_ON: table_on_r <= cfg_wdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      smp_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-1:1], in_valid};
      smp_r <= {smp_r[PIPE_DEPTH-1:1], in_kind};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wr_idx_r[1] <= in_entry_index;
      wr_val_r[1] <= in_entry_value;
      for (int k = 2; k <= CRD_IDX_LAT; k++) begin
        wr_idx_r[k] <= wr_idx_r[k-1];
        wr_val_r[k] <= wr_val_r[k-1];
      end
    end
  end

  // column axis
  bts_coord u_coord_a (
    .clk     (clk),
    .en      (en),
    .coord   (in_coord_a),
    .mode    (mode),
    .tap_idx (idx_a),
    .frac    (frac_a),
    .wgt     (wgt_a)
  );

  // row axis
  bts_coord u_coord_b (
    .clk     (clk),
    .en      (en),
    .coord   (in_coord_b),
    .mode    (mode),
    .tap_idx (idx_b),
    .frac    (frac_b),
    .wgt     (wgt_b)
  );

  // Writes and reads meet the table in the same slot, so item order holds.
  assign wr_fire = vld_r[CRD_IDX_LAT] & ~smp_r[CRD_IDX_LAT];
  assign rd_fire = vld_r[CRD_IDX_LAT] & smp_r[CRD_IDX_LAT];

  bts_table u_table (
    .clk      (clk),
    .en       (en),
    .wr_en    (wr_fire),
    .wr_index (wr_idx_r[CRD_IDX_LAT]),
    .wr_value (wr_val_r[CRD_IDX_LAT]),
    .rd_en    (rd_fire),
    .col      (idx_a),
    .row      (idx_b),
    .taps     (taps)
  );

  // Blend: r3 = a0*w1*w2 + f2*(a2*w1), r2 = a1*f1*w2 + f2*(a3*f1),
  // result = r3 + r2. Each product is packed before the next multiply;
  // the f2 terms are fused with their addend, one rounding.
  always_ff @(posedge clk) begin
    if (en) begin
      m0_17_r  <= fp_mul(taps.a0, wgt_a);
      m1_17_r  <= fp_mul(taps.a1, frac_a);
      m2_17_r  <= fp_mul(taps.a2, wgt_a);
      m3_17_r  <= fp_mul(taps.a3, frac_a);
      f2_17_r  <= frac_b;
      w2_17_r  <= wgt_b;

      p0_18_r  <= fp_pack(m0_17_r);
      p1_18_r  <= fp_pack(m1_17_r);
      p2_18_r  <= fp_pack(m2_17_r);
      p3_18_r  <= fp_pack(m3_17_r);
      f2_18_r  <= f2_17_r;
      w2_18_r  <= w2_17_r;

      n0_19_r  <= fp_mul(p0_18_r, w2_18_r);
      n1_19_r  <= fp_mul(p1_18_r, w2_18_r);
      q2_19_r  <= fp_mul(f2_18_r, p2_18_r);
      q3_19_r  <= fp_mul(f2_18_r, p3_18_r);

      r3a_20_r <= fp_pack(n0_19_r);
      r2a_20_r <= fp_pack(n1_19_r);
      q2_20_r  <= q2_19_r;
      q3_20_r  <= q3_19_r;

      r2x_21_r <= fp_add(q3_20_r, fp_unpack(r2a_20_r));
      r3x_21_r <= fp_add(q2_20_r, fp_unpack(r3a_20_r));

      r2_22_r  <= fp_pack(r2x_21_r);
      r3_22_r  <= fp_pack(r3x_21_r);

      sx_23_r  <= fp_add(fp_unpack(r3_22_r), fp_unpack(r2_22_r));

      res_24_r <= fp_pack(sx_23_r);
    end
  end

  // no table loaded: fixed -0.5
  assign out_sample_bits = table_on_r ? res_24_r : K_NO_TABLE;

  // clamped coordinates never reach the table edge, so no tap wraps
  ap_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_fire |-> (idx_a >= TAP_IDX_MIN && idx_a <= TAP_IDX_MAX &&
                 idx_b >= TAP_IDX_MIN && idx_b <= TAP_IDX_MAX))
    else $error("tap index outside clamped range");

  ap_frac_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[CRD_OUT_LAT] && smp_r[CRD_OUT_LAT]) |->
      (frac_a < K_ONE && frac_b < K_ONE))
    else $error("fraction not below one");

  ap_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(vld_r) && $stable(smp_r)))
    else $error("pipeline moved while held");

endmodule

/* verif/tb_bilinear_table_sampler.sv */
// Self-checking testbench for bilinear_table_sampler: directed table, random mix.
// Holds its own round-toward-zero float predictor of the sampler; needs bts_pkg and the RTL.
module tb_bilinear_table_sampler;
  import bts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORDS     = TABLE_SIDE * TABLE_SIDE;
  localparam int MAX_CYC   = 600000;
  localparam int DRAIN_CYC = 40;   // longer than the pipeline is deep

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [13:0] in_entry_index = '0;
  logic [31:0] in_entry_value = '0;
  logic [7:0]  in_selector = '0;
  logic [31:0] in_coord_a = '0;
  logic [31:0] in_coord_b = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_sample_bits;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_SEL_MASK;
  logic [7:0]  cfg_wdata = '0;

  bilinear_table_sampler dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  // Unpacked float: value = mant * 2^expo, same classes as the RTL package.
  typedef struct {
    fcls_t     cls;
    bit        sgn;
    bit [63:0] mant;
    int        expo;
  } ufl_t;

  // one input item; known/res carry a hand-typed expected result
  typedef struct {
    bit        kind;
    bit [13:0] idx;
    bit [31:0] val;
    bit [7:0]  sel;
    bit [31:0] ca;
    bit [31:0] cb;
    bit        known;
    bit [31:0] res;
  } req_t;

  bit [31:0] tbl_shadow [WORDS];
  bit        written [WORDS];
  bit [7:0]  mask_shadow;
  bit        present_shadow;
  bit [31:0] pending_samples[$];

  int errors = 0;
  int samples_checked = 0;
  int writes_sent = 0;
  int items_sent = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  bit long_hold_req = 1'b0;

  function automatic ufl_t ufl_split(bit [31:0] b);
    ufl_t x;
    x.sgn = b[31]; x.mant = 0; x.expo = 0;
    if (b[30:23] == 8'hFF) x.cls = (b[22:0] != 0) ? CL_NAN : CL_INF;
    else if (b[30:23] == 0) x.cls = CL_ZERO;
    else begin
      x.cls  = CL_FIN;
      x.mant = {40'd0, 1'b1, b[22:0]};
      x.expo = int'(b[30:23]) - 150;
    end
    return x;
  endfunction

  function automatic int top_bit(bit [63:0] m);
    int p;
    p = 63;
    while (p > 0 && !m[p]) p--;
    return p;
  endfunction

  // truncating pack with flush to zero and saturation to max finite
  function automatic bit [31:0] ufl_join(ufl_t x);
    int p;
    int be;
    bit [31:0] s;
    s = {x.sgn, 31'd0};
    if (x.cls == CL_NAN) return K_QNAN;
    if (x.cls == CL_INF) return s | K_INF;
    if (x.cls == CL_ZERO || x.mant == 0) return s;
    p = top_bit(x.mant);
    if (p > 23) begin x.mant >>= (p - 23); x.expo += p - 23; end
    else begin x.mant <<= (23 - p); x.expo -= 23 - p; end
    be = x.expo + 150;
    if (be >= 255) return s | K_MAX_FIN;
    if (be <= 0) return s;
    return {x.sgn, be[7:0], x.mant[22:0]};
  endfunction

  function automatic ufl_t ufl_mul(ufl_t a, ufl_t b);
    ufl_t r;
    r.sgn = a.sgn ^ b.sgn; r.mant = 0; r.expo = 0;
    if (a.cls == CL_NAN || b.cls == CL_NAN) r.cls = CL_NAN;
    else if (a.cls == CL_INF || b.cls == CL_INF)
      r.cls = (a.cls == CL_ZERO || b.cls == CL_ZERO) ? CL_NAN : CL_INF;
    else if (a.cls == CL_ZERO || b.cls == CL_ZERO) r.cls = CL_ZERO;
    else begin
      r.cls = CL_FIN; r.mant = a.mant * b.mant; r.expo = a.expo + b.expo;
    end
    return r;
  endfunction

  function automatic ufl_t ufl_align(ufl_t x);
    int sh;
    sh = 61 - top_bit(x.mant);
    x.mant <<= sh; x.expo -= sh;
    return x;
  endfunction

  // exact add with a sticky bit, rounding happens in ufl_join
  function automatic ufl_t ufl_add(ufl_t a, ufl_t b);
    ufl_t r;
    ufl_t t;
    int d;
    bit [63:0] ym;
    r.mant = 0; r.expo = 0; r.sgn = 0; r.cls = CL_ZERO;
    if (a.cls == CL_NAN || b.cls == CL_NAN) begin r.cls = CL_NAN; return r; end
    if (a.cls == CL_INF && b.cls == CL_INF) begin
      if (a.sgn != b.sgn) begin r.cls = CL_NAN; return r; end
      return a;
    end
    if (a.cls == CL_INF) return a;
    if (b.cls == CL_INF) return b;
    if (a.cls == CL_ZERO) begin
      if (b.cls == CL_ZERO) begin r.sgn = a.sgn & b.sgn; return r; end
      return b;
    end
    if (b.cls == CL_ZERO) return a;
    a = ufl_align(a); b = ufl_align(b);
    if (b.expo > a.expo || (b.expo == a.expo && b.mant > a.mant)) begin
      t = a; a = b; b = t;
    end
    d = a.expo - b.expo;
    if (d == 0) ym = b.mant;
    else if (d >= 64) ym = 1;
    else ym = (b.mant >> d) | 64'((b.mant << (64 - d)) != 0);
    r.cls = CL_FIN; r.expo = a.expo; r.sgn = a.sgn;
    r.mant = (a.sgn == b.sgn) ? a.mant + ym : a.mant - ym;
    if (r.mant == 0) begin r.cls = CL_ZERO; r.sgn = 0; end
    return r;
  endfunction

  function automatic bit [31:0] f_mul(bit [31:0] a, bit [31:0] b);
    return ufl_join(ufl_mul(ufl_split(a), ufl_split(b)));
  endfunction

  function automatic bit [31:0] f_add(bit [31:0] a, bit [31:0] b);
    return ufl_join(ufl_add(ufl_split(a), ufl_split(b)));
  endfunction

  function automatic bit [31:0] f_sub(bit [31:0] a, bit [31:0] b);
    return f_add(a, b ^ K_SIGN);
  endfunction

  // fused: a*b + c with a single rounding
  function automatic bit [31:0] f_mac(bit [31:0] a, bit [31:0] b, bit [31:0] c);
    return ufl_join(ufl_add(ufl_mul(ufl_split(a), ufl_split(b)), ufl_split(c)));
  endfunction

  function automatic bit f_greater(bit [31:0] a, bit [31:0] b);
    longint ka;
    longint kb;
    if (a[30:0] > K_INF[30:0] || b[30:0] > K_INF[30:0]) return 1'b0;
    ka = longint'(a[30:0]); if (a[31]) ka = -ka;
    kb = longint'(b[30:0]); if (b[31]) kb = -kb;
    return ka > kb;
  endfunction

  // float to int32, truncating and saturating; NaN gives the most negative
  function automatic bit [31:0] f_trunc_int(bit [31:0] b);
    ufl_t x;
    bit [31:0] mag;
    x = ufl_split(b);
    if (x.cls == CL_NAN) return K_INT_MIN;
    if (x.cls == CL_ZERO) return 0;
    if (x.cls == CL_INF || x.expo > 7) return x.sgn ? K_INT_MIN : K_INT_MAX;
    if (x.expo >= 0) mag = 32'(x.mant << x.expo);
    else if (x.expo <= -25) mag = 0;
    else mag = 32'(x.mant >> (-x.expo));
    return x.sgn ? 32'd0 - mag : mag;
  endfunction

  function automatic bit [31:0] f_from_int(bit [31:0] v);
    ufl_t x;
    if (v == 0) return 0;
    x.cls = CL_FIN; x.sgn = v[31]; x.expo = 0;
    x.mant = {32'd0, v[31] ? 32'd0 - v : v};
    return ufl_join(x);
  endfunction

  // mode 13: strip the nearest even multiple of ten
  function automatic bit [31:0] strip_even_tens(bit [31:0] c);
    bit [31:0] i;
    i = f_trunc_int(f_mul(c, K_TENTH));
    if (i[0]) i += i[31] ? 32'hFFFF_FFFF : 32'd1;
    return f_sub(c, f_from_int(i * 32'd10));
  endfunction

  function automatic bit [31:0] clamp_coord(bit [31:0] c);
    if (!f_greater(c, K_NEG12)) c = K_NEG12;
    if (!f_greater(K_POS12, c)) c = K_POS12;
    return c;
  endfunction

  function automatic bit [31:0] bilinear_sample(bit [7:0] sel_in, bit [31:0] a, bit [31:0] b);
    bit [7:0]  sel;
    bit [31:0] t1, t2, i1, i2, f1, f2, w1m, w2m, r2, r3;
    int        base;
    sel = sel_in & mask_shadow;
    if (sel == SEL_SCALE_A || sel == SEL_SCALE_B) begin
      a = f_mul(a, K_SCALE); b = f_mul(b, K_SCALE);
    end else if (sel == SEL_TENS) begin
      a = strip_even_tens(a); b = strip_even_tens(b);
    end
    if (!present_shadow) return K_NO_TABLE;
    a  = clamp_coord(a);
    b  = clamp_coord(b);
    t1 = f_mac(K_FIVE, a, K_SIXTYFOUR);
    t2 = f_mac(K_FIVE, b, K_SIXTYFOUR);
    i1 = f_trunc_int(t1);
    i2 = f_trunc_int(t2);
    f1 = f_sub(t1, f_from_int(i1));
    f2 = f_sub(t2, f_from_int(i2));
    base = int'(i1 % TABLE_SIDE) + int'(i2 % TABLE_SIDE) * TABLE_SIDE;
    w1m = f_sub(K_ONE, f1);
    w2m = f_sub(K_ONE, f2);
    r3 = f_mul(f_mul(tbl_shadow[base % WORDS], w1m), w2m);
    r2 = f_mul(f_mul(tbl_shadow[(base + 1) % WORDS], f1), w2m);
    r2 = f_mac(f2, f_mul(tbl_shadow[(base + TABLE_SIDE + 1) % WORDS], f1), r2);
    r3 = f_mac(f2, f_mul(tbl_shadow[(base + TABLE_SIDE) % WORDS], w1m), r3);
    return f_add(r3, r2);
  endfunction

  // top-left tap of a sample, as the predictor would address it
  function automatic int sample_base(bit [7:0] sel_in, bit [31:0] a, bit [31:0] b);
    bit [7:0]  sel;
    bit [31:0] i1, i2;
    sel = sel_in & mask_shadow;
    if (sel == SEL_SCALE_A || sel == SEL_SCALE_B) begin
      a = f_mul(a, K_SCALE); b = f_mul(b, K_SCALE);
    end else if (sel == SEL_TENS) begin
      a = strip_even_tens(a); b = strip_even_tens(b);
    end
    a  = clamp_coord(a);
    b  = clamp_coord(b);
    i1 = f_trunc_int(f_mac(K_FIVE, a, K_SIXTYFOUR));
    i2 = f_trunc_int(f_mac(K_FIVE, b, K_SIXTYFOUR));
    return int'(i1 % TABLE_SIDE) + int'(i2 % TABLE_SIDE) * TABLE_SIDE;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, bit [31:0] got, bit [31:0] want);
    $display("[%0t] mismatch %s: got %08h expected %08h", $realtime, what, got, want);
    errors++;
  endtask

  // outputs are sampled at the rising edge, before the block's own updates land
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected sample", out_sample_bits, 32'h0);
      end else begin
        if (out_sample_bits !== pending_samples[0])
          report_mismatch("sample_bits", out_sample_bits, pending_samples[0]);
        void'(pending_samples.pop_front());
        samples_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > MAX_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------- receiver
  // Random stall bursts, plus one long hold-off on request so the pipeline
  // backs up and the block has to push back on its input.
  always @(negedge clk) begin : stall_gen
    int burst;
    int hold_left;
    if (long_hold_req) begin
      hold_left = 400;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (burst > 0) begin
      out_stall = 1'b1;
      burst--;
    end else begin
      out_stall = 1'b0;
      if (idle_on && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 16);
    end
  end

  // ---------------------------------------------------------------- sender
  // Called at a falling edge; returns at the falling edge after acceptance.
  // Prediction runs at acceptance so table writes and samples stay in order.
  task automatic send_item(req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_kind        = r.kind;
    in_entry_index = r.idx;
    in_entry_value = r.val;
    in_selector    = r.sel;
    in_coord_a     = r.ca;
    in_coord_b     = r.cb;
    in_valid       = 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (!r.kind) begin
      tbl_shadow[r.idx] = r.val;
      written[r.idx]    = 1'b1;
      writes_sent++;
    end else if (r.known) begin
      pending_samples.push_back(r.res);
    end else begin
      pending_samples.push_back(bilinear_sample(r.sel, r.ca, r.cb));
    end
    @(negedge clk);
  endtask

  function automatic bit [31:0] rand_table_word();
    case ($urandom_range(0, 63))
      0: return K_QNAN;
      1: return K_INF | {1'($urandom_range(0, 1)), 31'd0};
      2: return K_MAX_FIN | {1'($urandom_range(0, 1)), 31'd0};
      3: return {1'($urandom_range(0, 1)), 8'd0, 23'($urandom)};  // denormal
      4: return $urandom;
      default: return f_mul(f_from_int(32'($urandom_range(0, 200000)) - 32'd100000),
                            32'h3A80_0000);
    endcase
  endfunction

  // with the table on, a sample only goes out once every tap it reads holds a written word
  task automatic send_checked(req_t r);
    int   base;
    int   tap[4];
    req_t w;
    if (r.kind && present_shadow) begin
      base   = sample_base(r.sel, r.ca, r.cb);
      tap[0] = base % WORDS;
      tap[1] = (base + 1) % WORDS;
      tap[2] = (base + TABLE_SIDE) % WORDS;
      tap[3] = (base + TABLE_SIDE + 1) % WORDS;
      foreach (tap[k]) begin
        if (!written[tap[k]]) begin
          w     = '{default: 0};
          w.idx = 14'(tap[k]);
          w.val = rand_table_word();
          send_item(w);
        end
      end
    end
    send_item(r);
  endtask

  // settle: nothing pending, then let in-flight writes retire
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] which, logic [7:0] data);
    cfg_we    = 1'b1;
    cfg_index = which;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (which == CFG_SEL_MASK) mask_shadow = data;
    else present_shadow = data[0];
  endtask

  function automatic bit [31:0] rand_coord();
    case ($urandom_range(0, 19))
      0, 1, 2: return $urandom;
      3: return K_QNAN | 32'($urandom_range(0, 255));
      4: return K_INF | {1'($urandom_range(0, 1)), 31'd0};
      5: return {1'($urandom_range(0, 1)), 8'd0, 23'($urandom)};
      6: return $urandom_range(0, 1) ? K_NEG12 : K_POS12;
      7: return f_mul(f_from_int(32'($urandom_range(0, 400)) - 32'd200), 32'h3F00_0000);
      default: return f_mul(f_from_int(32'($urandom_range(0, 64000)) - 32'd32000),
                            32'h3A83_126F);
    endcase
  endfunction

  function automatic req_t rand_item();
    req_t r;
    r = '{default: 0};
    r.kind = ($urandom_range(0, 3) != 0);
    r.idx  = 14'($urandom);
    r.val  = rand_table_word();
    r.sel  = $urandom_range(0, 1) ? 8'($urandom) :
             ($urandom_range(0, 2) == 0 ? SEL_SCALE_A :
              ($urandom_range(0, 1) ? SEL_SCALE_B : SEL_TENS));
    r.ca   = rand_coord();
    r.cb   = rand_coord();
    return r;
  endfunction

  // Directed rows. Rows with known=1 run right after reset, when there is no
  // table and every sample must come back as -0.5. The rest run once the
  // table is switched on and are checked against the predictor.
  req_t directed[] = '{
    '{1, 0, 0, 8'h00, 32'h0000_0000, 32'h0000_0000, 1, K_NO_TABLE},
    '{1, 0, 0, SEL_TENS, 32'h7FC0_0001, 32'h7F80_0000, 1, K_NO_TABLE},
    '{1, 0, 0, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0001, 1, K_NO_TABLE},
    '{0, 14'd0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0},
    '{0, 14'd16383, 32'h0000_0000, 0, 0, 0, 0, 0},
    '{0, 14'd8256, K_MAX_FIN, 0, 0, 0, 0, 0},
    '{0, 14'd8257, 32'h0000_0001, 0, 0, 0, 0, 0},
    '{1, 0, 0, 8'h00, 32'h0000_0000, 32'h0000_0000, 0, 0},
    '{1, 0, 0, 8'h00, 32'h3DCC_CCCD, 32'h3E00_0000, 0, 0},
    '{1, 0, 0, 8'h00, K_NEG12, K_POS12, 0, 0},
    '{1, 0, 0, 8'h00, 32'h4170_0000, 32'hC170_0000, 0, 0},
    '{1, 0, 0, 8'h00, 32'h7FC0_0000, 32'hFFFF_FFFF, 0, 0},
    '{1, 0, 0, 8'h00, 32'h7F80_0000, 32'hFF80_0000, 0, 0},
    '{1, 0, 0, 8'h00, 32'h8000_0000, 32'h0040_0000, 0, 0},
    '{1, 0, 0, 8'h00, 32'h3F7F_FFFF, 32'h4140_0001, 0, 0},
    '{1, 0, 0, SEL_SCALE_A, 32'h4120_0000, 32'h4120_0000, 0, 0},
    '{1, 0, 0, SEL_SCALE_B, 32'hC120_0000, 32'h40A0_0000, 0, 0},
    '{1, 0, 0, SEL_TENS, 32'h41C8_0000, 32'hC206_0000, 0, 0},
    '{1, 0, 0, SEL_TENS, 32'h7FC0_0001, 32'h7F80_0000, 0, 0},
    '{1, 0, 0, SEL_TENS, 32'h4F00_0000, 32'hCF80_0000, 0, 0},
    '{1, 0, 0, 8'hFF, K_MAX_FIN, 32'h0000_0000, 0, 0}
  };

  // random phases: {selector_mask, table_present}; the last one runs without idling
  bit [8:0] phase_cfg[6] = '{{8'hFF, 1'b1}, {8'h00, 1'b1}, {SEL_TENS, 1'b1},
                            {8'h07, 1'b1}, {8'hFF, 1'b0}, {8'hFF, 1'b1}};

  initial begin
    int phase_start;
    bit hold_sent;
    hold_sent      = 1'b0;
    mask_shadow    = '0;
    present_shadow = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // no table yet: fixed answer
    foreach (directed[k]) if (directed[k].known) send_checked(directed[k]);
    wait_idle();

    // taps are filled on demand so no sample taken with the table on touches an unwritten word
    write_reg(CFG_TABLE_ON, 8'h01);
    write_reg(CFG_SEL_MASK, 8'hFF);
    foreach (directed[k]) if (!directed[k].known) send_checked(directed[k]);
    wait_idle();

    foreach (phase_cfg[p]) begin
      write_reg(CFG_SEL_MASK, phase_cfg[p][8:1]);
      write_reg(CFG_TABLE_ON, {7'd0, phase_cfg[p][0]});
      idle_on     = (p != 5);
      phase_start = items_sent;
      while (items_sent - phase_start < 200) begin
        if (p == 1 && !hold_sent && items_sent - phase_start >= 20) begin
          long_hold_req = 1'b1;
          hold_sent     = 1'b1;
        end
        send_checked(rand_item());
      end
      wait_idle();
    end

    $display("checked %0d samples over %0d table writes, six mask/table settings,",
             samples_checked, writes_sent);
    $display("rescale modes, clamping and NaN/inf coordinates, with stalls on both sides");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
sv/bts_pkg.sv
sv/bts_coord.sv
sv/bts_table.sv
sv/bilinear_table_sampler.sv
verif/tb_bilinear_table_sampler.sv
